// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond implies expr in the same cycle
`define HSL2RGB_AST_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("hsl2rgb: implication check failed");

// sig may only rise if src was high in the previous cycle
`define HSL2RGB_AST_ROSE_FROM(label, clk, rst, sig, src) \
   label: assert property (@(posedge clk) disable iff (rst) $rose(sig) |-> $past(src)) \
      else $error("hsl2rgb: valid rose without a source item");

`endif

// ===== sv/hsl2rgb_pkg.sv =====
`default_nettype none

package hsl2rgb_pkg;

   // fixed point: unsigned, FRAC_BITS fractional bits, one = 2^FRAC_BITS
   localparam int FRAC_BITS = 16;
   localparam int FIX_W     = FRAC_BITS + 1;   // holds 0..one inclusive
   localparam int PROD_W    = 2 * FIX_W;
   localparam int VAL_W     = FIX_W + 1;       // clamped channel value
   localparam int SGN_W     = FIX_W + 2;       // signed channel value

   localparam logic [FIX_W-1:0] FIX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FIX_W-1:0] FIX_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

   // hue / 42 is done as (hue * one / 2 + 10) / 21 by reciprocal multiply
   localparam int HUE_NUM_W   = 8 + FRAC_BITS - 1;
   localparam int HUE_BIAS    = 10;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_21 = RECIP_W'(((1 << RECIP_SHIFT) + 20) / 21);
   localparam int HUE_PROD_W  = HUE_NUM_W + RECIP_W;

   localparam logic [7:0] HUE_SEC0_MAX = 8'd42;
   localparam logic [7:0] HUE_SEC1_MAX = 8'd85;
   localparam logic [7:0] HUE_SEC2_MAX = 8'd128;
   localparam logic [7:0] HUE_SEC3_MAX = 8'd170;
   localparam logic [7:0] HUE_SEC4_MAX = 8'd212;
   localparam logic [7:0] CHAN_MAX     = 8'd255;

   // which channels get chroma (c) and the second component (x)
   typedef enum logic [2:0] {
      SEC_RC_GX,
      SEC_RX_GC,
      SEC_GC_BX,
      SEC_GX_BC,
      SEC_RX_BC,
      SEC_RC_BX
   } sector_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] lightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/hsl2rgb_scale.sv =====
`default_nettype none

module hsl2rgb_scale (
   input  wire logic [hsl2rgb_pkg::VAL_W-1:0] value,
   output logic [7:0]                         chan
);
   import hsl2rgb_pkg::*;

   localparam int MUL_W = VAL_W + 8;

   logic [MUL_W-1:0] prod;
   logic [MUL_W:0]   sum;
   logic [MUL_W-FRAC_BITS:0] quot;

   // value * 255 as shift and subtract, round half up, saturate
   always_comb begin
      prod = {value, 8'd0} - MUL_W'(value);
      sum  = (MUL_W+1)'(prod) + (MUL_W+1)'(FIX_HALF);
      quot = sum[MUL_W:FRAC_BITS];
      if (quot > (MUL_W-FRAC_BITS+1)'(CHAN_MAX)) begin
         chan = CHAN_MAX;
      end else begin
         chan = quot[7:0];
      end
   end

endmodule

`default_nettype wire

// ===== sv/hsl_to_rgb_converter_unit.sv =====
`default_nettype none

// HSL to RGB pixel converter. Each item is one pixel of 8-bit hue (full
// circle = 0..255, six sectors of width 42), saturation and lightness; it
// gives one item of 8-bit red, green and blue. Math is unsigned fixed point
// with 16 fractional bits, rounding half up and saturating at 255, within
// 1 LSB of the float formula. The block keeps no state between pixels.
// Throughput is one pixel per clock while the output is not stalled;
// rsp_valid is set by the five register stages, the first of which loads
// at the accepting edge (normalize and hue multiply, chroma multiply,
// second-component multiply, sector select and offset, output scaling).
// Stages advance independently, so empty slots are filled while the
// output is stalled; req_stall rises only when every stage holds a pixel
// and the output is stalled.

`include "assert_macros.svh"

module hsl_to_rgb_converter_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire hsl2rgb_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output hsl2rgb_pkg::rsp_type      rsp_data
);
   import hsl2rgb_pkg::*;

   // ---- stage enables: a stage loads when empty or when it drains
   logic en_a, en_b, en_c, en_d, en_out;
   logic valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff, rsp_valid_ff;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_d      = !valid_d_ff || en_out;
   assign en_c      = !valid_c_ff || en_d;
   assign en_b      = !valid_b_ff || en_c;
   assign en_a      = !valid_a_ff || en_b;
   assign req_stall = !en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         valid_d_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a)   valid_a_ff   <= req_valid;
         if (en_b)   valid_b_ff   <= valid_a_ff;
         if (en_c)   valid_c_ff   <= valid_b_ff;
         if (en_d)   valid_d_ff   <= valid_c_ff;
         if (en_out) rsp_valid_ff <= valid_d_ff;
      end
   end

   // ---- stage A: s, l, one - |2l - one|, hue reciprocal product, sector
   logic [FIX_W-1:0]      sat_in, lig_in, omd_in;
   logic [FIX_W:0]        lig2, one_ext, lig_dist;
   logic [HUE_NUM_W-1:0]  hue_num;
   logic [HUE_PROD_W-1:0] hprod_in;
   sector_type            sec_in;

   logic [FIX_W-1:0]      sat_a_ff, lig_a_ff, omd_a_ff;
   logic [HUE_PROD_W-1:0] hprod_a_ff;
   sector_type            sec_a_ff;

   always_comb begin
      // x * 2^16 / 255 = x * 257 + x / 255, so rounding adds one for x >= 128
      sat_in  = {1'b0, req_data.saturation, req_data.saturation}
                + FIX_W'(req_data.saturation[7]);
      lig_in  = {1'b0, req_data.lightness, req_data.lightness}
                + FIX_W'(req_data.lightness[7]);
      lig2     = {lig_in, 1'b0};
      one_ext  = {1'b0, FIX_ONE};
      lig_dist = (lig2 >= one_ext) ? (lig2 - one_ext) : (one_ext - lig2);
      omd_in   = FIX_ONE - lig_dist[FIX_W-1:0];

      hue_num  = {req_data.hue, (FRAC_BITS-1)'(HUE_BIAS)};
      hprod_in = HUE_PROD_W'(hue_num) * HUE_PROD_W'(RECIP_21);

      if (req_data.hue <= HUE_SEC0_MAX) begin
         sec_in = SEC_RC_GX;
      end else if (req_data.hue <= HUE_SEC1_MAX) begin
         sec_in = SEC_RX_GC;
      end else if (req_data.hue <= HUE_SEC2_MAX) begin
         sec_in = SEC_GC_BX;
      end else if (req_data.hue <= HUE_SEC3_MAX) begin
         sec_in = SEC_GX_BC;
      end else if (req_data.hue <= HUE_SEC4_MAX) begin
         sec_in = SEC_RX_BC;
      end else begin
         sec_in = SEC_RC_BX;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         sat_a_ff   <= sat_in;
         lig_a_ff   <= lig_in;
         omd_a_ff   <= omd_in;
         hprod_a_ff <= hprod_in;
         sec_a_ff   <= sec_in;
      end
   end

   // ---- stage B: hue position mod 2, chroma product
   logic [FIX_W-1:0]  hmod, tdist, omt_in;
   logic [PROD_W-1:0] cprod_in;

   logic [FIX_W-1:0]  omt_b_ff, lig_b_ff;
   logic [PROD_W-1:0] cprod_b_ff;
   sector_type        sec_b_ff;

   always_comb begin
      hmod     = hprod_a_ff[RECIP_SHIFT +: FIX_W];
      tdist    = (hmod >= FIX_ONE) ? (hmod - FIX_ONE) : (FIX_ONE - hmod);
      omt_in   = FIX_ONE - tdist;
      cprod_in = PROD_W'(omd_a_ff) * PROD_W'(sat_a_ff);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         omt_b_ff   <= omt_in;
         lig_b_ff   <= lig_a_ff;
         cprod_b_ff <= cprod_in;
         sec_b_ff   <= sec_a_ff;
      end
   end

   // ---- stage C: round chroma, second-component product
   logic [PROD_W:0]   csum;
   logic [FIX_W-1:0]  chroma_in;
   logic [PROD_W-1:0] xprod_in;

   logic [FIX_W-1:0]  chroma_c_ff, lig_c_ff;
   logic [PROD_W-1:0] xprod_c_ff;
   sector_type        sec_c_ff;

   always_comb begin
      csum      = (PROD_W+1)'(cprod_b_ff) + (PROD_W+1)'(FIX_HALF);
      chroma_in = csum[FRAC_BITS +: FIX_W];
      xprod_in  = PROD_W'(chroma_in) * PROD_W'(omt_b_ff);
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         chroma_c_ff <= chroma_in;
         lig_c_ff    <= lig_b_ff;
         xprod_c_ff  <= xprod_in;
         sec_c_ff    <= sec_b_ff;
      end
   end

   // ---- stage D: round x, place c and x by sector, add offset, clamp
   logic [PROD_W:0]         xsum;
   logic [FIX_W-1:0]        xcomp, sel_r, sel_g, sel_b;
   logic signed [SGN_W-1:0] offs, v_r, v_g, v_b;
   logic [VAL_W-1:0]        red_in, green_in, blue_in;

   logic [VAL_W-1:0]        red_d_ff, green_d_ff, blue_d_ff;

   always_comb begin
      xsum  = (PROD_W+1)'(xprod_c_ff) + (PROD_W+1)'(FIX_HALF);
      xcomp = xsum[FRAC_BITS +: FIX_W];
      offs  = signed'(SGN_W'(lig_c_ff)) - signed'(SGN_W'(chroma_c_ff >> 1));

      sel_r = '0;
      sel_g = '0;
      sel_b = '0;
      unique case (sec_c_ff)
         SEC_RC_GX: begin sel_r = chroma_c_ff; sel_g = xcomp;       end
         SEC_RX_GC: begin sel_r = xcomp;       sel_g = chroma_c_ff; end
         SEC_GC_BX: begin sel_g = chroma_c_ff; sel_b = xcomp;       end
         SEC_GX_BC: begin sel_g = xcomp;       sel_b = chroma_c_ff; end
         SEC_RX_BC: begin sel_r = xcomp;       sel_b = chroma_c_ff; end
         SEC_RC_BX: begin sel_r = chroma_c_ff; sel_b = xcomp;       end
         default:   begin sel_r = '0;          sel_g = '0;          end
      endcase

      v_r = signed'(SGN_W'(sel_r)) + offs;
      v_g = signed'(SGN_W'(sel_g)) + offs;
      v_b = signed'(SGN_W'(sel_b)) + offs;

      // rounding can leave a channel slightly below zero
      red_in   = v_r[SGN_W-1] ? '0 : v_r[VAL_W-1:0];
      green_in = v_g[SGN_W-1] ? '0 : v_g[VAL_W-1:0];
      blue_in  = v_b[SGN_W-1] ? '0 : v_b[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         red_d_ff   <= red_in;
         green_d_ff <= green_in;
         blue_d_ff  <= blue_in;
      end
   end

   // ---- output stage: scale to 0..255
   rsp_type rsp_in;
   rsp_type rsp_ff;

   hsl2rgb_scale u_scale_red (
      .value (red_d_ff),
      .chan  (rsp_in.red)
   );

   hsl2rgb_scale u_scale_green (
      .value (green_d_ff),
      .chan  (rsp_in.green)
   );

   hsl2rgb_scale u_scale_blue (
      .value (blue_d_ff),
      .chan  (rsp_in.blue)
   );

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- checks
   `HSL2RGB_AST_IMPLY(a_omd_range, clock, reset, valid_a_ff, omd_a_ff <= FIX_ONE)
   `HSL2RGB_AST_IMPLY(a_chroma_range, clock, reset, valid_c_ff, chroma_c_ff <= FIX_ONE)
   `HSL2RGB_AST_IMPLY(a_stall_only_full, clock, reset, req_stall, valid_a_ff && valid_b_ff && valid_c_ff && valid_d_ff && rsp_valid_ff)
   `HSL2RGB_AST_ROSE_FROM(a_out_from_d, clock, reset, rsp_valid, valid_d_ff)

endmodule

`default_nettype wire

// ===== tb/tb_hsl_to_rgb_converter_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_hsl_to_rgb_converter_unit;
   import hsl2rgb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 12;       // pipeline is 5 deep

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // RGB values predicted for accepted pixels, oldest first
   rsp_type expected_rgb[$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;

   // current idling mix, percent of cycles
   int      sender_idle_pct  = 0;
   int      rsp_stall_pct    = 0;

   hsl_to_rgb_converter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Fixed-point HSL to RGB predictor, 64-bit math throughout
   // ------------------------------------------------------------------

   // clamp below zero, scale to 0..255 with half-up rounding, saturate
   function automatic logic [7:0] scale_level(longint v);
      longint unsigned half;
      longint unsigned u;
      longint unsigned r;
      half = (64'd1 << FRAC_BITS) >> 1;
      u = (v < 0) ? 64'd0 : longint'(v);
      r = (u * 255 + half) >> FRAC_BITS;
      if (r > 255)
         r = 255;
      return r[7:0];
   endfunction

   function automatic rsp_type convert_hsl(req_type px);
      longint unsigned one;
      longint unsigned half;
      longint unsigned sat_q;
      longint unsigned lig_q;
      longint unsigned lig_dist;
      longint unsigned chroma;
      longint unsigned hue_q;
      longint unsigned hue_mod2;
      longint unsigned hue_tri;
      longint unsigned second;
      longint unsigned rv;
      longint unsigned gv;
      longint unsigned bv;
      longint          offset;
      rsp_type         o;
      one   = 64'd1 << FRAC_BITS;
      half  = one >> 1;
      sat_q = (longint'(px.saturation) * one + 127) / 255;
      lig_q = (longint'(px.lightness) * one + 127) / 255;
      lig_dist = (2 * lig_q >= one) ? 2 * lig_q - one : one - 2 * lig_q;
      chroma = ((one - lig_dist) * sat_q + half) >> FRAC_BITS;
      hue_q    = (longint'(px.hue) * one + 21) / 42;
      hue_mod2 = hue_q & (2 * one - 1);
      hue_tri  = (hue_mod2 >= one) ? hue_mod2 - one : one - hue_mod2;
      second   = (chroma * (one - hue_tri) + half) >> FRAC_BITS;
      offset   = longint'(lig_q) - longint'(chroma >> 1);
      rv = 0;
      gv = 0;
      bv = 0;
      // six sectors, upper bounds inclusive
      if (px.hue <= HUE_SEC0_MAX) begin
         rv = chroma; gv = second;
      end else if (px.hue <= HUE_SEC1_MAX) begin
         rv = second; gv = chroma;
      end else if (px.hue <= HUE_SEC2_MAX) begin
         gv = chroma; bv = second;
      end else if (px.hue <= HUE_SEC3_MAX) begin
         gv = second; bv = chroma;
      end else if (px.hue <= HUE_SEC4_MAX) begin
         rv = second; bv = chroma;
      end else begin
         rv = chroma; bv = second;
      end
      o.red   = scale_level(longint'(rv) + offset);
      o.green = scale_level(longint'(gv) + offset);
      o.blue  = scale_level(longint'(bv) + offset);
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard: predict on input handshake, compare on output handshake.
   // Sampled at the rising edge, before the edge's updates land.
   // ------------------------------------------------------------------

   function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_rgb.push_back(convert_hsl(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual r=%0d g=%0d b=%0d",
                        $time, rsp_data.red, rsp_data.green, rsp_data.blue);
               mismatch_count++;
            end else begin
               want = expected_rgb.pop_front();
               check_channel("red",   want.red,   rsp_data.red);
               check_channel("green", want.green, rsp_data.green);
               check_channel("blue",  want.blue,  rsp_data.blue);
            end
         end
      end
   end

   // random output back-pressure, per current phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_hsl_to_rgb_converter_unit: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // present one pixel, with random idle cycles ahead of it, and hold it
   // until accepted; valid stays high afterwards for back-to-back items
   task automatic send_pixel(logic [7:0] hue, logic [7:0] sat, logic [7:0] lig);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.hue        <= hue;
      req_data.saturation <= sat;
      req_data.lightness  <= lig;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // stop sending until every predicted item has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rgb.size() != 0)
         @(posedge clock);
   endtask

   // mostly uniform, sometimes a corner value
   function automatic logic [7:0] pick_level();
      logic [7:0] corners[8] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255, 8'd42, 8'd213};
      if ($urandom_range(99) < 15)
         return corners[$urandom_range(7)];
      return 8'($urandom_range(255));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // sector boundaries, grey and black/white extremes, bit patterns
   task automatic test_directed();
      logic [7:0] edges[12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                                8'd129, 8'd170, 8'd171, 8'd212, 8'd213, 8'd255};
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      // every sector edge, full saturation, mid lightness
      foreach (edges[i])
         send_pixel(edges[i], 8'd255, 8'd128);
      send_pixel(8'd0,   8'd0,   8'd0);     // black
      send_pixel(8'd255, 8'd255, 8'd255);   // white, overflow side
      send_pixel(8'd100, 8'd0,   8'd200);   // grey, no chroma
      send_pixel(8'd21,  8'd255, 8'd127);   // just below half lightness
      send_pixel(8'd200, 8'd255, 8'd1);     // near black, negative channel side
      send_pixel(8'd64,  8'd255, 8'd254);   // near white
      send_pixel(8'hAA,  8'h55,  8'hAA);
      send_pixel(8'h55,  8'hAA,  8'h55);
      send_pixel(8'd150, 8'd1,   8'd128);
      send_pixel(8'd230, 8'd128, 8'd64);
      wait_for_drain();
   endtask

   task automatic test_random_phase(int count, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      repeat (count)
         send_pixel(pick_level(), pick_level(), pick_level());
      wait_for_drain();
   endtask

   // sender holds off mid-phase until the pipe is empty, then resumes
   task automatic test_pause_for_drain();
      sender_idle_pct = 0;
      rsp_stall_pct   = 40;
      repeat (20)
         send_pixel(pick_level(), pick_level(), pick_level());
      wait_for_drain();
      repeat (20)
         send_pixel(pick_level(), pick_level(), pick_level());
      wait_for_drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(150, 0, 0);      // full rate
      test_random_phase(150, 61, 0);     // sparse input
      test_random_phase(150, 0, 61);     // heavy back-pressure
      test_random_phase(150, 24, 24);    // both sides idle
      test_pause_for_drain();

      // let any stray item surface
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rgb.size() == 0) begin
         $display("tb_hsl_to_rgb_converter_unit: PASS");
      end else begin
         $display("tb_hsl_to_rgb_converter_unit: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/hsl2rgb_pkg.sv
sv/hsl2rgb_scale.sv
sv/hsl_to_rgb_converter_unit.sv
tb/tb_hsl_to_rgb_converter_unit.sv
